// ----- rtl/assert_macros.svh -----
// Assertion helpers shared by the RTL files.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef NO_ASSERTIONS

// Property that must hold at every clock edge outside reset.
`define ASSERT_ALWAYS(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Antecedent in this cycle implies consequent in the next cycle.
`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`else

`define ASSERT_ALWAYS(lbl, clk, rst_n, prop, msg)
`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg)

`endif

`endif

// ----- rtl/rpn_pkg.sv -----
package rpn_pkg;

    localparam int STACK_DEPTH = 16;
    localparam int CNT_W       = $clog2(STACK_DEPTH + 1);
    localparam int ADDR_W      = (STACK_DEPTH > 2) ? $clog2(STACK_DEPTH) : 1;
    localparam int DATA_W      = 32;

    localparam logic [2:0] OP_PUSH   = 3'd0;
    localparam logic [2:0] OP_ADD    = 3'd1;
    localparam logic [2:0] OP_SUB    = 3'd2;
    localparam logic [2:0] OP_MUL    = 3'd3;
    localparam logic [2:0] OP_FINISH = 3'd4;

    localparam logic [2:0] ST_ACCEPTED = 3'd0;
    localparam logic [2:0] ST_OK       = 3'd1;
    localparam logic [2:0] ST_LEFTOVER = 3'd2;
    localparam logic [2:0] ST_FAILED   = 3'd3;
    localparam logic [2:0] ST_OVERFLOW = 3'd4;

    typedef struct packed {
        logic [2:0]               operation;
        logic signed [DATA_W-1:0] operand_value;
    } cmd_t;

    typedef struct packed {
        logic signed [DATA_W-1:0] top_value;
        logic                     top_invalid;
        logic [4:0]               stack_depth;
        logic [2:0]               status;
    } res_t;

    // One stack entry: invalid mark plus Q16.16 value.
    typedef struct packed {
        logic                     inv;
        logic signed [DATA_W-1:0] val;
    } entry_t;

endpackage

// ----- rtl/rpn_ram.sv -----
module rpn_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // Read-first: a same-address write is not visible until the next read.
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

// ----- rtl/rpn_alu.sv -----
module rpn_alu
    import rpn_pkg::*;
(
    input  logic [2:0]               op,
    input  logic signed [DATA_W-1:0] x,   // top
    input  logic signed [DATA_W-1:0] y,   // second
    output logic signed [DATA_W-1:0] result
);

    localparam logic signed [DATA_W-1:0] SAT_MAX = {1'b0, {(DATA_W-1){1'b1}}};
    localparam logic signed [DATA_W-1:0] SAT_MIN = {1'b1, {(DATA_W-1){1'b0}}};

    logic signed [DATA_W:0]     sum;
    logic signed [2*DATA_W-1:0] prod;
    logic signed [2*DATA_W-1:0] rnd;
    logic signed [2*DATA_W-1:0] q;
    logic                       q_fits;
    logic signed [DATA_W-1:0]   add_sat;
    logic signed [DATA_W-1:0]   mul_sat;

    always_comb
    begin
        if (op == OP_SUB)
        begin
            sum = {y[DATA_W-1], y} - {x[DATA_W-1], x};
        end
        else
        begin
            sum = {y[DATA_W-1], y} + {x[DATA_W-1], x};
        end

        if (sum[DATA_W] != sum[DATA_W-1])
        begin
            add_sat = sum[DATA_W] ? SAT_MIN : SAT_MAX;
        end
        else
        begin
            add_sat = sum[DATA_W-1:0];
        end

        // Round to nearest, ties up, then floor shift by 16.
        prod   = (2*DATA_W)'(x) * (2*DATA_W)'(y);
        rnd    = prod + (2*DATA_W)'(32768);
        q      = rnd >>> 16;
        q_fits = (q[2*DATA_W-1:DATA_W-1] == {(DATA_W+1){1'b0}})
              || (q[2*DATA_W-1:DATA_W-1] == {(DATA_W+1){1'b1}});
        if (q_fits)
        begin
            mul_sat = q[DATA_W-1:0];
        end
        else
        begin
            mul_sat = q[2*DATA_W-1] ? SAT_MIN : SAT_MAX;
        end

        result = (op == OP_MUL) ? mul_sat : add_sat;
    end

endmodule

// ----- rtl/rpn_stack_evaluator_top.sv -----
// Channel | Handshake              | Payload (rpn_pkg)  | Direction
// cmd     | cmd_valid / cmd_ready  | cmd_t: op, value   | into block
// res     | res_valid / res_ready  | res_t: top, status | out of block
//
// One transaction in, one transaction out, one per clock when res is not stalled.
// Result appears in the output register the cycle after the command is taken.
// Top and second entries live in registers; deeper entries live in one RAM whose
// next-to-pop entry is prefetched every cycle, with a forward path for spill writes.
// Async active-low reset clears the count, overflow flag, forward flag and output valid; no RAM clear.
// cmd_ready drops only while a result waits and res_ready is low.
`include "assert_macros.svh"

module rpn_stack_evaluator_top
    import rpn_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  logic cmd_valid,
    output logic cmd_ready,
    input  cmd_t cmd,
    output logic res_valid,
    input  logic res_ready,
    output res_t res
);

    // Stack state: count, two register-held entries, overflow flag
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    entry_t           top_reg, top_next;
    entry_t           nos_reg, nos_next;
    logic             ovf_reg, ovf_next;

    // RAM holds entries 0 .. cnt-3; read port is aimed at entry cnt-3
    logic             mem_we;
    logic [ADDR_W-1:0] mem_waddr;
    logic [ADDR_W-1:0] mem_raddr;
    entry_t           mem_rdata;
    logic             fwd_reg, fwd_next;
    entry_t           fwd_data_reg;
    entry_t           third;

    // Output register
    logic             res_valid_reg;
    res_t             res_reg, res_next;

    logic             accept;
    logic signed [DATA_W-1:0] alu_out;
    logic             bin_inv;
    logic [CNT_W-1:0] rd_idx;

    assign cmd_ready = !res_valid_reg || res_ready;
    assign accept    = cmd_valid && cmd_ready;
    assign res_valid = res_valid_reg;
    assign res       = res_reg;

    // Third entry: RAM read, or the spill that was written into that slot last cycle
    assign third = fwd_reg ? fwd_data_reg : mem_rdata;

    rpn_alu u_alu (
        .op     (cmd.operation),
        .x      (top_reg.val),
        .y      (nos_reg.val),
        .result (alu_out)
    );

    rpn_ram #(
        .WIDTH ($bits(entry_t)),
        .DEPTH (STACK_DEPTH),
        .AW    (ADDR_W)
    ) u_stack_ram (
        .clk   (clk),
        .we    (mem_we),
        .waddr (mem_waddr),
        .wdata (nos_reg),
        .raddr (mem_raddr),
        .rdata (mem_rdata)
    );

    always_comb
    begin
        cnt_next  = cnt_reg;
        top_next  = top_reg;
        nos_next  = nos_reg;
        ovf_next  = ovf_reg;
        mem_we    = 1'b0;
        mem_waddr = ADDR_W'(cnt_reg - CNT_W'(2));
        bin_inv   = top_reg.inv || nos_reg.inv;
        res_next  = res_reg;

        if (accept)
        begin
            case (cmd.operation)
                OP_PUSH:
                begin
                    if (cnt_reg < CNT_W'(STACK_DEPTH))
                    begin
                        // Spill second entry into RAM once two are held
                        mem_we       = (cnt_reg >= CNT_W'(2));
                        nos_next     = top_reg;
                        top_next.val = cmd.operand_value;
                        top_next.inv = 1'b0;
                        cnt_next     = cnt_reg + CNT_W'(1);
                    end
                    else
                    begin
                        ovf_next = 1'b1;
                    end
                end
                OP_ADD, OP_SUB, OP_MUL:
                begin
                    if (cnt_reg >= CNT_W'(2))
                    begin
                        top_next.inv = bin_inv;
                        top_next.val = bin_inv ? '0 : alu_out;
                        nos_next     = third;
                        cnt_next     = cnt_reg - CNT_W'(1);
                    end
                    else
                    begin
                        // Too few operands: top becomes (or is pushed as) invalid
                        top_next.inv = 1'b1;
                        top_next.val = '0;
                        cnt_next     = CNT_W'(1);
                    end
                end
                OP_FINISH:
                begin
                    cnt_next = '0;
                    ovf_next = 1'b0;
                end
                default:
                begin
                end
            endcase

            if (cmd.operation == OP_FINISH)
            begin
                res_next.top_invalid = (cnt_reg == '0) || top_reg.inv;
                res_next.top_value   = res_next.top_invalid ? '0 : top_reg.val;
                res_next.stack_depth = '0;
                if (ovf_reg)
                begin
                    res_next.status = ST_OVERFLOW;
                end
                else if (cnt_reg >= CNT_W'(2))
                begin
                    res_next.status = ST_LEFTOVER;
                end
                else if (res_next.top_invalid)
                begin
                    res_next.status = ST_FAILED;
                end
                else
                begin
                    res_next.status = ST_OK;
                end
            end
            else
            begin
                res_next.top_invalid = (cnt_next == '0) || top_next.inv;
                res_next.top_value   = res_next.top_invalid ? '0 : top_next.val;
                res_next.stack_depth = 5'(cnt_next);
                res_next.status      = ovf_next ? ST_OVERFLOW : ST_ACCEPTED;
            end
        end

        // Prefetch the entry that becomes second after the next pop
        rd_idx    = cnt_next - CNT_W'(3);
        mem_raddr = ADDR_W'(rd_idx);
        // A spill always lands on the slot just prefetched
        fwd_next  = mem_we;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg       <= '0;
            ovf_reg       <= 1'b0;
            fwd_reg       <= 1'b0;
            res_valid_reg <= 1'b0;
        end
        else
        begin
            cnt_reg <= cnt_next;
            ovf_reg <= ovf_next;
            fwd_reg <= fwd_next;
            if (accept)
            begin
                res_valid_reg <= 1'b1;
            end
            else if (res_ready)
            begin
                res_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        top_reg      <= top_next;
        nos_reg      <= nos_next;
        fwd_data_reg <= nos_reg;
        res_reg      <= res_next;
    end

    `ASSERT_ALWAYS(a_cnt_bound, clk, rst_n, cnt_reg <= CNT_W'(STACK_DEPTH), "count beyond depth")
    `ASSERT_ALWAYS(a_fwd_deep, clk, rst_n, !fwd_reg || (cnt_reg >= CNT_W'(3)), "forward without RAM entry")
    `ASSERT_NEXT(a_finish_clears, clk, rst_n, accept && (cmd.operation == OP_FINISH), (cnt_reg == '0) && !ovf_reg, "finish left state")
    `ASSERT_NEXT(a_accept_result, clk, rst_n, accept, res_valid, "accepted command gave no result")

endmodule

// ----- bench/rpn_stack_evaluator_top_test.sv -----
// Self-checking bench for the RPN stack evaluator.
// A predictor mirrors the operand stack, the invalid marks and the sticky
// overflow flag, and works out the result transaction for every command
// transaction the block accepts. The checker compares each result with the
// oldest prediction, one field at a time.
module rpn_stack_evaluator_top_test;
    import rpn_pkg::*;

    localparam int CYCLE_LIMIT = 200000;
    localparam int REPORT_MAX  = 10;

    // Q16.16 extremes and the saturation bounds used by the predictor.
    localparam logic signed [DATA_W-1:0] FX_MAX  = 32'sh7FFF_FFFF;
    localparam logic signed [DATA_W-1:0] FX_MIN  = 32'sh8000_0000;
    localparam logic signed [DATA_W-1:0] FX_ONE  = 32'sh0001_0000;
    localparam logic signed [DATA_W-1:0] FX_HALF = 32'sh0000_8000;
    localparam longint SAT_HI = 64'sd2147483647;
    localparam longint SAT_LO = -64'sd2147483648;

    logic clk       = 1'b0;
    logic rst_n     = 1'b0;
    logic cmd_valid = 1'b0;
    logic cmd_ready;
    cmd_t cmd       = '0;
    logic res_valid;
    logic res_ready = 1'b0;
    res_t res;

    rpn_stack_evaluator_top uut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd_valid (cmd_valid),
        .cmd_ready (cmd_ready),
        .cmd       (cmd),
        .res_valid (res_valid),
        .res_ready (res_ready),
        .res       (res)
    );

    always #5 clk = ~clk;

    // ------------------------------------------------------------------
    // Predictor state: a private copy of the operand stack.
    // ------------------------------------------------------------------
    logic signed [DATA_W-1:0] stack_val [STACK_DEPTH];
    bit                       stack_inv [STACK_DEPTH];
    int                       stack_cnt = 0;
    bit                       ovf_flag  = 1'b0;

    // Results predicted but not yet seen on the result channel, oldest first.
    res_t pending_results [$];

    // Idle/stall knobs, in percent per cycle, and a forced receiver hold-off.
    int send_idle_pct  = 0;
    int recv_stall_pct = 0;
    int hold_left      = 0;

    int error_count    = 0;
    int sent_count     = 0;
    int checked_count  = 0;
    int finish_count   = 0;
    int ovf_reports    = 0;
    int cycle_count    = 0;

    logic [2:0] arith_ops [3] = '{OP_ADD, OP_SUB, OP_MUL};

    // Applies one token to the shadow stack and returns what the block must report.
    function automatic res_t evaluate_token(cmd_t c);
        res_t                     r;
        longint                   x;
        longint                   y;
        longint                   p;
        logic signed [DATA_W-1:0] v;
        bit                       bad;
        r = '0;
        if (c.operation == OP_FINISH)
        begin
            v   = '0;
            bad = 1'b1;     // empty stack pops an invalid value
            if (stack_cnt > 0)
            begin
                stack_cnt--;
                v   = stack_val[stack_cnt];
                bad = stack_inv[stack_cnt];
            end
            if (ovf_flag)
                r.status = ST_OVERFLOW;
            else if (stack_cnt > 0)
                r.status = ST_LEFTOVER;
            else if (bad)
                r.status = ST_FAILED;
            else
                r.status = ST_OK;
            stack_cnt     = 0;
            ovf_flag      = 1'b0;
            r.top_value   = bad ? '0 : v;
            r.top_invalid = bad;
            r.stack_depth = '0;
            return r;
        end

        case (c.operation)
            OP_PUSH:
            begin
                if (stack_cnt < STACK_DEPTH)
                begin
                    stack_val[stack_cnt] = c.operand_value;
                    stack_inv[stack_cnt] = 1'b0;
                    stack_cnt++;
                end
                else
                    ovf_flag = 1'b1;
            end
            OP_ADD, OP_SUB, OP_MUL:
            begin
                if (stack_cnt >= 2)
                begin
                    x   = stack_val[stack_cnt-1];
                    y   = stack_val[stack_cnt-2];
                    bad = stack_inv[stack_cnt-1] || stack_inv[stack_cnt-2];
                    if (c.operation == OP_ADD)
                        p = y + x;
                    else if (c.operation == OP_SUB)
                        p = y - x;
                    else
                        p = (x * y + 64'sd32768) >>> 16;  // nearest, ties up
                    if (p > SAT_HI)
                        p = SAT_HI;
                    if (p < SAT_LO)
                        p = SAT_LO;
                    stack_cnt--;
                    stack_val[stack_cnt-1] = bad ? '0 : p[DATA_W-1:0];
                    stack_inv[stack_cnt-1] = bad;
                end
                else
                begin
                    // one entry: it turns invalid; none: an invalid entry appears
                    stack_val[0] = '0;
                    stack_inv[0] = 1'b1;
                    stack_cnt    = 1;
                end
            end
            default: ;
        endcase

        r.status = ovf_flag ? ST_OVERFLOW : ST_ACCEPTED;
        if (stack_cnt > 0)
        begin
            r.top_invalid = stack_inv[stack_cnt-1];
            r.top_value   = r.top_invalid ? '0 : stack_val[stack_cnt-1];
            r.stack_depth = 5'(stack_cnt);
        end
        else
        begin
            r.top_value   = '0;
            r.top_invalid = 1'b1;
            r.stack_depth = '0;
        end
        return r;
    endfunction

    // Mostly small Q16.16 values so that products stay in range, plus extremes and random words.
    function automatic logic signed [DATA_W-1:0] rand_q();
        logic signed [DATA_W-1:0] v;
        case ($urandom_range(0, 9))
            0:       v = FX_MAX;
            1:       v = FX_MIN;
            2, 3:    v = $urandom;
            default:
            begin
                v = $urandom_range(0, 32'h000F_FFFF);
                if ($urandom_range(0, 1))
                    v = -v;
            end
        endcase
        return v;
    endfunction

    // ------------------------------------------------------------------
    // Command side. Valid goes up without looking at ready and holds until
    // the transaction is taken; the prediction is queued at that edge.
    // ------------------------------------------------------------------
    task automatic send_token(input logic [2:0] op, input logic signed [DATA_W-1:0] value);
        cmd_t c;
        int   gap;
        c.operation     = op;
        c.operand_value = value;
        gap = 0;
        while (gap < 20 && $urandom_range(0, 99) < send_idle_pct)
            gap++;
        if (gap > 0)
        begin
            cmd_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        cmd_valid <= 1'b1;
        cmd       <= c;
        @(posedge clk);
        while (!cmd_ready)
            @(posedge clk);
        pending_results.push_back(evaluate_token(c));
        sent_count++;
        if (op == OP_FINISH)
            finish_count++;
    endtask

    // Drops valid and holds the sender until every predicted result is back.
    task automatic wait_drain();
        cmd_valid <= 1'b0;
        while (pending_results.size() > 0)
            @(posedge clk);
    endtask

    // One expression with random content; most are well formed.
    task automatic rand_expression();
        int kind;
        int operands;
        int pushed;
        int extra;
        kind = $urandom_range(0, 19);
        if (kind < 14)
        begin
            operands = $urandom_range(1, ($urandom_range(0, 3) == 0) ? STACK_DEPTH : 5);
            pushed   = 0;
            while (pushed < operands || stack_cnt > 1)
            begin
                if (pushed < operands && (stack_cnt < 2 || $urandom_range(0, 1)))
                begin
                    send_token(OP_PUSH, rand_q());
                    pushed++;
                end
                else
                    send_token(arith_ops[$urandom_range(0, 2)], $urandom);
            end
            send_token(OP_FINISH, $urandom);
        end
        else if (kind < 16)
        begin
            // leftover operands at finish
            operands = $urandom_range(2, 6);
            repeat (operands)
            begin
                send_token(OP_PUSH, rand_q());
                if ($urandom_range(0, 3) == 0)
                    send_token(arith_ops[$urandom_range(0, 2)], $urandom);
            end
            send_token(OP_FINISH, $urandom);
        end
        else if (kind < 18)
        begin
            // noise; the stack carries over into the next expression
            repeat ($urandom_range(1, 8))
                send_token(3'($urandom_range(OP_PUSH, OP_FINISH)), rand_q());
        end
        else if (kind == 18)
        begin
            // push past the top of the stack
            extra = STACK_DEPTH - stack_cnt + $urandom_range(1, 3);
            repeat (extra)
                send_token(OP_PUSH, rand_q());
            repeat ($urandom_range(0, 2))
                send_token(arith_ops[$urandom_range(0, 2)], $urandom);
            send_token(OP_FINISH, $urandom);
        end
        else
        begin
            // operators on a short stack
            send_token(OP_FINISH, $urandom);
            repeat ($urandom_range(1, 3))
                send_token(arith_ops[$urandom_range(0, 2)], $urandom);
            if ($urandom_range(0, 1))
                send_token(OP_PUSH, rand_q());
            send_token(OP_FINISH, $urandom);
        end
    endtask

    // ------------------------------------------------------------------
    // Result side: ready with random stalls, or held low for a counted
    // stretch when a test asks for it.
    // ------------------------------------------------------------------
    always @(posedge clk)
    begin
        if (hold_left > 0)
        begin
            res_ready <= 1'b0;
            hold_left <= hold_left - 1;
        end
        else
            res_ready <= ($urandom_range(0, 99) >= recv_stall_pct);
    end

    // Every result transaction is matched against the oldest prediction.
    always @(posedge clk)
    begin : check_results
        res_t want;
        if (rst_n && res_valid && res_ready)
        begin
            checked_count++;
            if (pending_results.size() == 0)
            begin
                if (error_count < REPORT_MAX)
                    $display("[%0t] unexpected result: value=%h inv=%b depth=%0d status=%0d",
                             $realtime, res.top_value, res.top_invalid,
                             res.stack_depth, res.status);
                error_count++;
            end
            else
            begin
                want = pending_results.pop_front();
                if (want.status == ST_OVERFLOW)
                    ovf_reports++;
                if (res.top_value !== want.top_value || res.top_invalid !== want.top_invalid
                    || res.stack_depth !== want.stack_depth || res.status !== want.status)
                begin
                    if (error_count < REPORT_MAX)
                    begin
                        $write("[%0t] mismatch: value exp %h got %h, inv exp %b got %b, ",
                               $realtime, want.top_value, res.top_value,
                               want.top_invalid, res.top_invalid);
                        $display("depth exp %0d got %0d, status exp %0d got %0d",
                                 want.stack_depth, res.stack_depth,
                                 want.status, res.status);
                    end
                    error_count++;
                end
            end
        end
    end

    // Watchdog.
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("Timeout after %0d cycles, %0d results outstanding",
                     cycle_count, pending_results.size());
            $display("CHECKS FAILED");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------

    // Saturating add/sub/mul at the Q16.16 extremes and the multiply tie rounding.
    task automatic test_arith_extremes();
        send_token(OP_PUSH, FX_MAX);
        send_token(OP_PUSH, FX_MAX);
        send_token(OP_ADD, '0);             // clips high
        send_token(OP_PUSH, FX_MIN);
        send_token(OP_SUB, '0);             // second minus top, clips high
        send_token(OP_PUSH, FX_MIN);
        send_token(OP_ADD, FX_MAX);         // -1 lsb
        send_token(OP_PUSH, FX_HALF);
        send_token(OP_MUL, FX_MIN);         // negative tie rounds up to zero
        send_token(OP_PUSH, 32'sd1);
        send_token(OP_PUSH, FX_HALF);
        send_token(OP_MUL, '1);             // positive tie rounds up to one lsb
        send_token(OP_ADD, '0);
        send_token(OP_PUSH, FX_MIN);
        send_token(OP_PUSH, FX_MIN);
        send_token(OP_MUL, '0);             // huge product clips high
        send_token(OP_ADD, '0);
        send_token(OP_FINISH, '0);          // clean result
        wait_drain();
    endtask

    // Invalid entries from short stacks, their spread, and the failed and leftover finish outcomes.
    task automatic test_short_stack();
        send_token(OP_ADD, '0);             // empty: an invalid entry appears
        send_token(OP_SUB, '0);             // one entry: it stays invalid
        send_token(OP_PUSH, 5 * FX_ONE);
        send_token(OP_MUL, '0);             // invalid operand spreads
        send_token(OP_FINISH, '1);          // invalid, nothing left: failed
        send_token(OP_FINISH, '0);          // empty stack: failed
        send_token(OP_PUSH, 2 * FX_ONE);
        send_token(OP_PUSH, 3 * FX_ONE);
        send_token(OP_FINISH, '0);          // leftover operands
        wait_drain();
    endtask

    // Receiver holds off while pushes keep coming: the block backs up and the
    // stack overflows. Overflow sticks until finish, then a clean expression.
    task automatic test_overflow_backpressure();
        int saved_idle;
        saved_idle    = send_idle_pct;
        send_idle_pct = 0;
        hold_left     = 80;
        repeat (STACK_DEPTH + 2)
            send_token(OP_PUSH, rand_q());
        send_token(OP_ADD, '0);
        send_token(OP_FINISH, '0);
        send_token(OP_PUSH, FX_ONE);
        send_token(OP_FINISH, '0);
        wait_drain();
        send_idle_pct = saved_idle;
    endtask

    task automatic test_random_expressions(input int count, input int idle_pct,
                                           input int stall_pct);
        int target;
        send_idle_pct  = idle_pct;
        recv_stall_pct = stall_pct;
        target = sent_count + count;
        while (sent_count < target)
            rand_expression();
        wait_drain();
    endtask

    initial
    begin
        send_idle_pct  = 10;
        recv_stall_pct = 61;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_arith_extremes();
        test_short_stack();
        test_random_expressions(300, 10, 61);
        test_overflow_backpressure();
        test_random_expressions(300, 61, 10);
        test_random_expressions(300, 0, 0);

        recv_stall_pct = 0;
        repeat (10) @(posedge clk);
        if (pending_results.size() != 0)
        begin
            $display("%0d predicted results never arrived", pending_results.size());
            error_count++;
        end

        $display("Covered %0d command transactions, %0d results checked, %0d finishes,",
                 sent_count, checked_count, finish_count);
        $display("%0d overflow reports, under three idle/stall mixes and a long hold-off.",
                 ovf_reports);
        if (error_count == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

endmodule
